// ----- rtl/core/rgb_median_filter_3x3_macros.svh -----
// Assertion macros for the RGB 3x3 median filter.
// Used by the port checker; no other dependencies.
`ifndef RGB_MEDIAN_FILTER_3X3_MACROS_SVH
`define RGB_MEDIAN_FILTER_3X3_MACROS_SVH

// Implication checked outside reset
`define RMF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmf check failed");

// Implication checked at every edge, reset included
`define RMF_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("rmf check failed");

`endif

// ----- rtl/core/rmf_pkg.sv -----
// Shared types and constants for the RGB 3x3 median filter.
// No dependencies.
package rmf_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int CHANNEL_BITS = 8;
  localparam int PIX_BITS     = 3 * CHANNEL_BITS;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
  localparam int WIDTH_BITS   = 12;
  localparam int HEIGHT_BITS  = 13;
  localparam int CFG_BITS     = 13;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef logic [PIX_BITS-1:0] pix_t;

  // One column of the window with the position flags of its result
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
    logic emit;
    logic row_first;
    logic row_last;
    logic col_first;
    logic col_last;
  } col_req_t;

endpackage

// ----- rtl/core/rmf_stream_if.sv -----
// Valid/ready channels for the RGB 3x3 median filter.
// Depends on rmf_pkg.
interface rmf_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [rmf_pkg::CHANNEL_BITS-1:0]   red_in;
  logic [rmf_pkg::CHANNEL_BITS-1:0]   green_in;
  logic [rmf_pkg::CHANNEL_BITS-1:0]   blue_in;
  modport source (output valid, op, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface rmf_out_if;
  logic                               valid;
  logic                               ready;
  logic [rmf_pkg::CHANNEL_BITS-1:0]   red_out;
  logic [rmf_pkg::CHANNEL_BITS-1:0]   green_out;
  logic [rmf_pkg::CHANNEL_BITS-1:0]   blue_out;
  logic                               frame_last;
  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// ----- rtl/core/rgb_median_filter_3x3.sv -----
// RGB 3x3 median filter, top level: front end, request queue, median back end.
// Throughput: one request per cycle unless a full queue holds the input; the line
// stores take one read per request. Path: stage, queue, window, output registers.
// Results trail the pixels by one row plus one pixel; drain ticks flush the rest.
// Reset (synchronous, rst_n low): counters, queue and window clear, size 640x480;
// line store contents are kept and need no clearing pass.
module rgb_median_filter_3x3 (
  input  logic                         clk,
  input  logic                         rst_n,
  rmf_in_if.sink                       in_ch,
  rmf_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [rmf_pkg::CFG_BITS-1:0] cfg_wdata
);

  logic              push, pop, q_full, q_not_empty;
  rmf_pkg::col_req_t push_data, pop_data;

  rmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rmf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  rmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (q_not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/core/rmf_front.sv -----
// Front end: accepts requests, tracks frame position, runs the line stores.
// Depends on rmf_pkg and rmf_stream_if.
module rmf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  rmf_in_if.sink                        in_ch,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [rmf_pkg::CFG_BITS-1:0]  cfg_wdata,
  output logic                          push,
  output rmf_pkg::col_req_t             push_data,
  input  logic                          q_full
);

  logic [rmf_pkg::WIDTH_BITS-1:0]  width_r;
  logic [rmf_pkg::HEIGHT_BITS-1:0] height_r;
  logic [rmf_pkg::WIDTH_BITS-1:0]  eff_w;
  logic [rmf_pkg::HEIGHT_BITS-1:0] eff_h;

  logic [rmf_pkg::COL_BITS-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [rmf_pkg::ROW_BITS-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic                         draining_r, draining_nxt;

  logic [rmf_pkg::WIDTH_BITS-1:0]  in_col_inc, out_col_inc;
  logic [rmf_pkg::HEIGHT_BITS-1:0] in_row_inc, out_row_inc;

  logic acc, take, is_pix, emit, last;
  logic row_first, row_last, col_first, col_last;
  logic [rmf_pkg::COL_BITS-1:0] rd_col;

  rmf_pkg::pix_t pix;
  rmf_pkg::pix_t mem_a [rmf_pkg::MAX_WIDTH];
  rmf_pkg::pix_t mem_b [rmf_pkg::MAX_WIDTH];
  rmf_pkg::pix_t a_rd_r, b_rd_r;

  logic                         bwr_pend_r;
  logic [rmf_pkg::COL_BITS-1:0] bwr_col_r;

  logic          s1_valid_r;
  logic          s1_emit_r, s1_rf_r, s1_rl_r, s1_cf_r, s1_cl_r;
  rmf_pkg::pix_t s1_bot_r;

  // Saturate frame size
  always_comb begin
    eff_w = width_r;
    if (width_r < rmf_pkg::WIDTH_BITS'(2)) eff_w = rmf_pkg::WIDTH_BITS'(2);
    if (width_r > rmf_pkg::WIDTH_BITS'(rmf_pkg::MAX_WIDTH))
      eff_w = rmf_pkg::WIDTH_BITS'(rmf_pkg::MAX_WIDTH);
    eff_h = height_r;
    if (height_r < rmf_pkg::HEIGHT_BITS'(2)) eff_h = rmf_pkg::HEIGHT_BITS'(2);
    if (height_r > rmf_pkg::HEIGHT_BITS'(rmf_pkg::MAX_HEIGHT))
      eff_h = rmf_pkg::HEIGHT_BITS'(rmf_pkg::MAX_HEIGHT);
  end

  assign in_ch.ready = !s1_valid_r || !q_full;
  assign acc    = in_ch.valid && in_ch.ready;
  assign is_pix = !draining_r && (in_ch.op == rmf_pkg::OP_PIXEL);
  assign take   = acc && (draining_r || in_ch.op == rmf_pkg::OP_PIXEL);
  assign pix    = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};

  assign in_col_inc  = rmf_pkg::WIDTH_BITS'(in_col_r) + 1'b1;
  assign out_col_inc = rmf_pkg::WIDTH_BITS'(out_col_r) + 1'b1;
  assign in_row_inc  = rmf_pkg::HEIGHT_BITS'(in_row_r) + 1'b1;
  assign out_row_inc = rmf_pkg::HEIGHT_BITS'(out_row_r) + 1'b1;

  // Classify the request and pick the store column
  assign emit = !is_pix || (in_row_r >= rmf_pkg::ROW_BITS'(2)) ||
                (in_row_r == rmf_pkg::ROW_BITS'(1) && in_col_r != '0);
  assign rd_col = is_pix ? in_col_r :
                  (out_col_inc < eff_w) ? out_col_inc[rmf_pkg::COL_BITS-1:0] : '0;
  assign row_first = (out_row_r == '0);
  assign row_last  = (out_row_inc >= eff_h);
  assign col_first = (out_col_r == '0);
  assign col_last  = (out_col_inc >= eff_w);
  assign last      = row_last && col_last;

  // Advance the frame counters
  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    draining_nxt = draining_r;
    if (take) begin
      if (is_pix) begin
        if (in_col_inc >= eff_w) begin
          in_col_nxt = '0;
          if (in_row_inc >= eff_h) begin
            in_row_nxt   = '0;
            draining_nxt = 1'b1;
          end else begin
            in_row_nxt = in_row_inc[rmf_pkg::ROW_BITS-1:0];
          end
        end else begin
          in_col_nxt = in_col_inc[rmf_pkg::COL_BITS-1:0];
        end
      end
      if (emit) begin
        if (last) begin
          in_col_nxt   = '0;
          in_row_nxt   = '0;
          out_col_nxt  = '0;
          out_row_nxt  = '0;
          draining_nxt = 1'b0;
        end else if (col_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_inc[rmf_pkg::ROW_BITS-1:0];
        end else begin
          out_col_nxt = out_col_inc[rmf_pkg::COL_BITS-1:0];
        end
      end
    end
  end

  // Hold configuration and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= rmf_pkg::WIDTH_RESET;
      height_r   <= rmf_pkg::HEIGHT_RESET;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      draining_r <= 1'b0;
    end else if (cfg_we) begin
      if (rmf_pkg::cfg_idx_t'(cfg_addr) == rmf_pkg::CFG_FRAME_WIDTH) begin
        width_r <= cfg_wdata[rmf_pkg::WIDTH_BITS-1:0];
      end else begin
        height_r <= cfg_wdata;
      end
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      draining_r <= 1'b0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      draining_r <= draining_nxt;
    end
  end

  // Line store A: previous row, read before write
  always_ff @(posedge clk) begin
    if (take) begin
      a_rd_r <= mem_a[rd_col];
      if (is_pix) mem_a[rd_col] <= pix;
    end
  end

  // Line store B: row before that, fed from A in the cycle after the read
  always_ff @(posedge clk) begin
    if (take) b_rd_r <= mem_b[rd_col];
    if (bwr_pend_r) mem_b[bwr_col_r] <= a_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bwr_pend_r <= 1'b0;
    end else begin
      bwr_pend_r <= take && is_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (take) bwr_col_r <= rd_col;
  end

  // Stage register in front of the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_emit_r <= emit;
      s1_rf_r   <= row_first;
      s1_rl_r   <= row_last;
      s1_cf_r   <= col_first;
      s1_cl_r   <= col_last;
      s1_bot_r  <= is_pix ? pix : '0;
    end
  end

  assign push = s1_valid_r && !q_full;
  always_comb begin
    push_data.top       = b_rd_r;
    push_data.mid       = a_rd_r;
    push_data.bot       = s1_bot_r;
    push_data.emit      = s1_emit_r;
    push_data.row_first = s1_rf_r;
    push_data.row_last  = s1_rl_r;
    push_data.col_first = s1_cf_r;
    push_data.col_last  = s1_cl_r;
  end

endmodule

// ----- rtl/core/rmf_queue.sv -----
// Short request queue between the front end and the median back end.
// Depends on rmf_pkg.
module rmf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rmf_pkg::col_req_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output rmf_pkg::col_req_t pop_data
);

  rmf_pkg::col_req_t              entry_r [rmf_pkg::Q_DEPTH];
  logic [rmf_pkg::Q_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [rmf_pkg::Q_PTR_BITS:0]   count_r;

  assign full      = (count_r == (rmf_pkg::Q_PTR_BITS+1)'(rmf_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- rtl/core/rmf_back.sv -----
// Back end: shifts the 3x3 window and registers the per-channel medians.
// Depends on rmf_pkg and rmf_stream_if.
module rmf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              not_empty,
  input  rmf_pkg::col_req_t pop_data,
  output logic              pop,
  rmf_out_if.source         out_ch
);

  typedef logic [8:0][rmf_pkg::CHANNEL_BITS-1:0] chan_win_t;

  rmf_pkg::pix_t win_r [9];
  logic          win_valid_r;
  logic          rf_r, rl_r, cf_r, cl_r;
  logic          move;
  logic [8:0]    mask;
  chan_win_t     rv, gv, bv;

  logic [rmf_pkg::CHANNEL_BITS-1:0] red_r, green_r, blue_r;
  logic                             last_r, out_valid_r;

  // Upper median of the masked values: rank by value, ties by position
  function automatic logic [rmf_pkg::CHANNEL_BITS-1:0] chan_med(
      input chan_win_t v, input logic [8:0] m);
    logic [3:0] n;
    logic [3:0] rank;
    logic [rmf_pkg::CHANNEL_BITS-1:0] res;
    n   = 4'($countones(m));
    res = '0;
    for (int i = 0; i < 9; i++) begin
      rank = '0;
      for (int j = 0; j < 9; j++) begin
        if (m[j] && (v[j] < v[i] || (v[j] == v[i] && j < i))) rank = rank + 1'b1;
      end
      if (m[i] && rank == (n >> 1)) res = v[i];
    end
    return res;
  endfunction

  assign move = win_valid_r && (!out_valid_r || out_ch.ready);
  assign pop  = not_empty && (!win_valid_r || move);

  // Shift the window on every popped column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else if (pop) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= pop_data.top;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= pop_data.mid;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= pop_data.bot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
    end else if (pop) begin
      win_valid_r <= pop_data.emit;
    end else if (move) begin
      win_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rf_r <= pop_data.row_first;
      rl_r <= pop_data.row_last;
      cf_r <= pop_data.col_first;
      cl_r <= pop_data.col_last;
    end
  end

  // Drop out-of-image neighbors
  always_comb begin
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        mask[y*3+x] = !((y == 0 && rf_r) || (y == 2 && rl_r) ||
                        (x == 0 && cf_r) || (x == 2 && cl_r));
      end
    end
    for (int k = 0; k < 9; k++) begin
      rv[k] = win_r[k][3*rmf_pkg::CHANNEL_BITS-1:2*rmf_pkg::CHANNEL_BITS];
      gv[k] = win_r[k][2*rmf_pkg::CHANNEL_BITS-1:rmf_pkg::CHANNEL_BITS];
      bv[k] = win_r[k][rmf_pkg::CHANNEL_BITS-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      red_r   <= chan_med(rv, mask);
      green_r <= chan_med(gv, mask);
      blue_r  <= chan_med(bv, mask);
      last_r  <= rl_r && cl_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red_out    = red_r;
  assign out_ch.green_out  = green_r;
  assign out_ch.blue_out   = blue_r;
  assign out_ch.frame_last = last_r;

endmodule

// ----- rtl/core/rmf_checker.sv -----
// Port-level checks for the RGB 3x3 median filter, bound to the top level.
// Depends on rmf_pkg and rgb_median_filter_3x3_macros.svh.
`include "rgb_median_filter_3x3_macros.svh"

module rmf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rmf_pkg::CHANNEL_BITS-1:0]  out_red,
  input logic                              out_last
);

  // A stalled result holds
  `RMF_ASSERT_IMPL(a_out_hold, $past(out_valid && !out_ready) && $past(rst_n), out_valid && $stable(out_red) && $stable(out_last))
  // A stalled request stays offered
  `RMF_ASSERT_IMPL(a_in_hold, $past(in_valid && !in_ready) && $past(rst_n), in_valid)
  // No result right after reset
  `RMF_ASSERT_ALWAYS(a_out_idle_after_reset, $past(!rst_n) && rst_n, !out_valid)
  // Input side open right after reset
  `RMF_ASSERT_ALWAYS(a_in_ready_after_reset, $past(!rst_n) && rst_n, in_ready)

endmodule

bind rgb_median_filter_3x3 rmf_checker u_rmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.red_out),
  .out_last  (out_ch.frame_last)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the RGB 3x3 median filter: random pixel frames, drain ticks, resizes.
// Depends on rmf_pkg, rmf_stream_if and rgb_median_filter_3x3.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    rmf_pkg::op_t op;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
  } pix_req_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } med_pix_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  rmf_pkg::cfg_idx_t cfg_addr;
  logic [rmf_pkg::CFG_BITS-1:0] cfg_wdata;

  rmf_in_if  in_ch ();
  rmf_out_if out_ch ();

  rgb_median_filter_3x3 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  pix_req_t pend_q[$];
  med_pix_t median_q[$];
  int       errors = 0;
  int       n_results = 0;

  // Predictor state
  logic [11:0] p_width;
  logic [12:0] p_height;
  logic [23:0] row1_mem[rmf_pkg::MAX_WIDTH];
  logic [23:0] row2_mem[rmf_pkg::MAX_WIDTH];
  logic [23:0] win[9];
  int in_col, in_row, out_col, out_row;
  bit flushing;

  function automatic int width_eff();
    if (p_width < 2) return 2;
    if (p_width > rmf_pkg::MAX_WIDTH) return rmf_pkg::MAX_WIDTH;
    return p_width;
  endfunction

  function automatic int height_eff();
    if (p_height < 2) return 2;
    if (p_height > rmf_pkg::MAX_HEIGHT) return rmf_pkg::MAX_HEIGHT;
    return p_height;
  endfunction

  function automatic logic [7:0] win_median(int shift, int w, int h);
    logic [7:0] v[9];
    logic [7:0] val;
    int n;
    int k;
    n = 0;
    for (int y = 0; y < 3; y++) begin
      if (y == 0 && out_row == 0) continue;
      if (y == 2 && out_row + 1 >= h) continue;
      for (int x = 0; x < 3; x++) begin
        if (x == 0 && out_col == 0) continue;
        if (x == 2 && out_col + 1 >= w) continue;
        val = 8'(win[y*3+x] >> shift);
        k = n;
        while (k > 0 && v[k-1] > val) begin
          v[k] = v[k-1];
          k--;
        end
        v[k] = val;
        n++;
      end
    end
    return v[n/2];
  endfunction

  task automatic restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; flushing = 0;
  endtask

  // Advance the window by one request and queue the median it produces
  task automatic predict_median(pix_req_t r);
    int w, h, col;
    logic [23:0] top, mid, bot;
    bit emit;
    med_pix_t m;
    w = width_eff();
    h = height_eff();
    if (!flushing && r.op == rmf_pkg::OP_DRAIN) return;
    if (!flushing) begin
      col = in_col;
      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
      top = row2_mem[col];
      mid = row1_mem[col];
      bot = {r.red, r.green, r.blue};
      row2_mem[col] = mid;
      row1_mem[col] = bot;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          flushing = 1;
        end
      end
    end else begin
      col = (out_col + 1 < w) ? out_col + 1 : 0;
      emit = 1;
      top = row2_mem[col];
      mid = row1_mem[col];
      bot = '0;
    end
    for (int y = 0; y < 3; y++) begin
      win[y*3] = win[y*3+1];
      win[y*3+1] = win[y*3+2];
    end
    win[2] = top; win[5] = mid; win[8] = bot;
    if (!emit) return;
    m.red = win_median(16, w, h);
    m.green = win_median(8, w, h);
    m.blue = win_median(0, w, h);
    m.last = out_row + 1 >= h && out_col + 1 >= w;
    median_q.push_back(m);
    if (m.last) restart_frame();
    else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // Clock
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Driver: offer pending requests with random gaps
  int  in_gap = 0;
  bit  in_burst = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        predict_median('{rmf_pkg::op_t'(in_ch.op), in_ch.red_in, in_ch.green_in,
                         in_ch.blue_in});
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 11);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        pix_req_t r;
        r = pend_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op <= r.op;
        in_ch.red_in <= r.red;
        in_ch.green_in <= r.green;
        in_ch.blue_in <= r.blue;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long hold-off of the receiver, started once after some results
  int  hold_cnt = 0;
  bit  held = 0;
  always @(posedge clk) begin
    if (!held && n_results >= 40) begin
      held = 1;
      hold_cnt = 600;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
    end
  end

  // Monitor: check each result, stall at random
  int  out_gap = 0;
  bit  out_burst = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (median_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h %h %h last=%b", out_ch.red_out,
                                     out_ch.green_out, out_ch.blue_out, out_ch.frame_last);
        end else begin
          med_pix_t m;
          m = median_q.pop_front();
          if (m.red !== out_ch.red_out || m.green !== out_ch.green_out ||
              m.blue !== out_ch.blue_out || m.last !== out_ch.frame_last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h %h %h last=%b, got %h %h %h last=%b",
                       m.red, m.green, m.blue, m.last, out_ch.red_out, out_ch.green_out,
                       out_ch.blue_out, out_ch.frame_last);
          end
        end
        if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
        out_gap = out_burst ? 0 : $urandom_range(0, 11);
      end
      if (hold_cnt > 0) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (pend_q.size() != 0 || in_ch.valid || median_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(rmf_pkg::cfg_idx_t idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= rmf_pkg::CFG_BITS'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rmf_pkg::CFG_FRAME_WIDTH) p_width = 12'(value);
    else p_height = 13'(value);
    restart_frame();
  endtask

  task automatic set_size(int w, int h);
    wait_idle();
    write_reg(rmf_pkg::CFG_FRAME_WIDTH, w);
    write_reg(rmf_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  function automatic logic [7:0] chan_val(int mode);
    case (mode)
      1: return 8'h00;
      2: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Queue one frame; noise adds ignored drain ticks, cut stops before the frame is done
  task automatic push_frame(int w, int h, int mode, bit noise, int cut);
    pix_req_t r;
    int n;
    n = 0;
    for (int i = 0; i < w*h; i++) begin
      if (cut > 0 && n >= cut) return;
      if (noise && $urandom_range(0, 7) == 0) begin
        r = '{rmf_pkg::OP_DRAIN, chan_val(0), chan_val(0), chan_val(0)};
        pend_q.push_back(r);
      end
      r = '{rmf_pkg::OP_PIXEL, chan_val(mode == 3 ? $urandom_range(1, 2) : mode),
            chan_val(mode == 3 ? $urandom_range(1, 2) : mode),
            chan_val(mode == 3 ? $urandom_range(1, 2) : mode)};
      pend_q.push_back(r);
      n++;
    end
    // Flush: drain ticks mixed with pixels that only act as drain ticks
    for (int i = 0; i <= w; i++) begin
      r = '{rmf_pkg::op_t'($urandom_range(0, 1)), chan_val(0), chan_val(0), chan_val(0)};
      pend_q.push_back(r);
    end
  endtask

  initial begin
    int w, h, items;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = rmf_pkg::CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = rmf_pkg::OP_PIXEL;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    out_ch.ready = 1'b0;
    p_width = 640;
    p_height = 480;
    for (int i = 0; i < rmf_pkg::MAX_WIDTH; i++) begin
      row1_mem[i] = '0;
      row2_mem[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: partial frame at reset size, then tiny frames with extreme values
    push_frame(640, 480, 0, 1, 6);
    set_size(2, 2);
    push_frame(2, 2, 1, 0, 0);
    push_frame(2, 2, 2, 1, 0);
    set_size(0, 1);
    push_frame(2, 2, 3, 1, 0);
    set_size(3, 3);
    push_frame(3, 3, 3, 0, 0);

    // Random frames of small sizes, a few abandoned by a resize
    items = 0;
    while (items < 900) begin
      w = $urandom_range(2, 9);
      h = $urandom_range(2, 7);
      set_size(w, h);
      if ($urandom_range(0, 9) == 0) begin
        push_frame(w, h, 0, 1, $urandom_range(1, w*h - 1));
        set_size(w, h);
      end
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        push_frame(w, h, $urandom_range(0, 4) == 0 ? 3 : 0, $urandom_range(0, 1), 0);
        items += w*h + w + 1;
      end
    end

    // Register values beyond the largest sizes, on partial frames, then one full small frame
    set_size(4095, 8191);
    push_frame(2048, 4096, 0, 0, 200);
    set_size(2, 8191);
    push_frame(2, 4096, 0, 1, 100);
    set_size(5, 4);
    push_frame(5, 4, 0, 1, 0);

    wait_idle();
    if (errors == 0 && median_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #6000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- rgb_median_filter_3x3.f -----
+incdir+rtl/core
rtl/core/rmf_pkg.sv
rtl/core/rmf_stream_if.sv
rtl/core/rmf_front.sv
rtl/core/rmf_queue.sv
rtl/core/rmf_back.sv
rtl/core/rgb_median_filter_3x3.sv
rtl/core/rmf_checker.sv
tb/sv/tb_top.sv
